@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Operation and status codes and the field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned PRIO_W = 32;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CNT_W  = 7;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept as a sorted list
// Entries live in two memories ordered from the head; each has one read and one write port.
// One sequencer walks the list an entry per cycle to search and shift.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_*     slave      op kind (tuser), priority, key, position (tdata)
// out_*    master     status, found, entry, count (tdata)
//
// Push, remove, contains and pop walk the stored entries one at a time,
// since the memories have a single read port; read fetches only the
// addressed entry. Full, empty and undefined requests answer at once.
// Reset empties the queue at once (stores are not cleared). in_tready is low
// from acceptance until the result transfer on the output completes, so a
// new request is taken only after the previous result has been passed on.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: priority_req[31:0], entry_x[39:32], entry_y[47:40],
  // entry_symbol[55:48], entry_speed[63:56], position[69:64], zero fill
  input  logic [71:0] in_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[1:0], found[2], out_priority[34:3], out_x[42:35],
  // out_y[50:43], out_symbol[58:51], out_speed[66:59], count[73:67], zero fill
  output logic [79:0] out_tdata
);
  import spq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_SCAN, S_SHR, S_SHL, S_RDPOS, S_WAIT, S_DONE, S_OUT
  } state_t;

  logic [PRIO_W-1:0] prio_mem [DEPTH];
  logic [KEY_W-1:0]  key_mem  [DEPTH];

  state_t            state_r;
  op_t               op_r;
  logic [PRIO_W-1:0] req_prio_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [OW-1:0]     occ_r;
  logic [OW-1:0]     idx_r;       // address issued this cycle
  logic [OW-1:0]     didx_r;      // index of data now on the read registers
  logic              dvalid_r;
  logic [PRIO_W-1:0] rd_prio_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [OW-1:0]     hit_r;
  status_t           status_r;
  logic              found_r;
  logic [PRIO_W-1:0] oprio_r;
  logic [KEY_W-1:0]  okey_r;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [PRIO_W-1:0] wr_prio;
  logic [KEY_W-1:0]  wr_key;
  logic [AW-1:0]     rd_addr;
  logic              prio_lt;     // stored entry lower than the request

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign prio_lt    = $signed(rd_prio_r) < $signed(req_prio_r);
  assign rd_addr    = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    rd_prio_r <= prio_mem[rd_addr];
    rd_key_r  <= key_mem[rd_addr];
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
      key_mem[wr_addr]  <= wr_key;
    end
  end

  // Write port: shifts copy the read entry one place up or down; push stores the request.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = didx_r[AW-1:0];
    wr_prio = rd_prio_r;
    wr_key  = rd_key_r;
    case (state_r)
      S_SHR: begin
        if (dvalid_r) begin
          wr_en   = 1'b1;
          wr_addr = AW'(didx_r + 1'b1);
        end
      end
      S_SHL: begin
        if (dvalid_r) begin
          wr_en   = 1'b1;
          wr_addr = AW'(didx_r - 1'b1);
        end
      end
      S_DONE: begin
        if (op_r == OP_PUSH && status_r == ST_OK) begin
          wr_en   = 1'b1;
          wr_addr = hit_r[AW-1:0];
          wr_prio = req_prio_r;
          wr_key  = req_key_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      dvalid_r <= 1'b0;
    end else begin
      dvalid_r <= 1'b0;
      didx_r   <= idx_r;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= op_t'(in_tuser);
            req_prio_r <= in_tdata[31:0];
            req_key_r  <= in_tdata[63:32];
            status_r   <= ST_OK;
            found_r    <= 1'b0;
            oprio_r    <= '0;
            okey_r     <= '0;
            idx_r      <= '0;
            hit_r      <= '0;
            case (in_tuser)
              OP_PUSH: begin
                if (occ_r == OW'(DEPTH)) begin
                  status_r <= ST_FULL;
                  state_r  <= S_OUT;
                end else if (occ_r == '0) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_RD0;
                end
              end
              OP_POP: begin
                if (occ_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_OUT;
                end else begin
                  state_r <= S_RD0;
                end
              end
              OP_REMOVE, OP_CONTAINS: begin
                if (occ_r == '0) begin
                  status_r <= (in_tuser == OP_REMOVE) ? ST_NOTFOUND : ST_OK;
                  state_r  <= S_OUT;
                end else begin
                  state_r <= S_RD0;
                end
              end
              OP_READ: begin
                if (int'(in_tdata[69:64]) >= int'(occ_r)) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_OUT;
                end else begin
                  idx_r   <= OW'(in_tdata[69:64]);
                  state_r <= S_RDPOS;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        // Address 0 issued; next cycle scan starts with its data.
        S_RD0: begin
          dvalid_r <= 1'b1;
          idx_r    <= idx_r + 1'b1;
          state_r  <= S_SCAN;
        end
        S_SCAN: begin
          if (dvalid_r) begin
            case (op_r)
              OP_PUSH: begin
                // Head is passed while its priority is lower or equal; later entries
                // advance while stored priority is strictly lower than the request.
                if ((didx_r == '0) ? !prio_lt && (rd_prio_r != req_prio_r)
                                   : !prio_lt) begin
                  hit_r    <= didx_r;
                  idx_r    <= occ_r - 1'b1;
                  state_r  <= S_WAIT;
                end else if (didx_r + 1'b1 == occ_r) begin
                  hit_r   <= occ_r;
                  state_r <= S_DONE;
                end else begin
                  dvalid_r <= 1'b1;
                  idx_r    <= idx_r + 1'b1;
                end
              end
              OP_POP: begin
                oprio_r  <= rd_prio_r;
                okey_r   <= rd_key_r;
                hit_r    <= '0;
                idx_r    <= OW'(1);
                state_r  <= S_WAIT;
              end
              default: begin
                if (rd_key_r == req_key_r) begin
                  found_r <= (op_r == OP_CONTAINS);
                  hit_r   <= didx_r;
                  idx_r   <= didx_r + 1'b1;
                  state_r <= (op_r == OP_REMOVE) ? S_WAIT : S_OUT;
                end else if (didx_r + 1'b1 == occ_r) begin
                  status_r <= (op_r == OP_REMOVE) ? ST_NOTFOUND : ST_OK;
                  state_r  <= S_OUT;
                end else begin
                  dvalid_r <= 1'b1;
                  idx_r    <= idx_r + 1'b1;
                end
              end
            endcase
          end
        end
        // Launch the first read of the shift pass; a removal at the tail has nothing to shift.
        S_WAIT: begin
          if (op_r == OP_PUSH) begin
            dvalid_r <= 1'b1;
            idx_r    <= idx_r - 1'b1;
            state_r  <= S_SHR;
          end else if (idx_r >= occ_r) begin
            state_r <= S_DONE;
          end else begin
            dvalid_r <= 1'b1;
            idx_r    <= idx_r + 1'b1;
            state_r  <= S_SHL;
          end
        end
        S_SHR: begin
          if (didx_r == hit_r) begin
            state_r <= S_DONE;
          end else begin
            dvalid_r <= 1'b1;
            idx_r    <= idx_r - 1'b1;
          end
        end
        S_SHL: begin
          if (didx_r + 1'b1 >= occ_r) begin
            state_r <= S_DONE;
          end else begin
            dvalid_r <= 1'b1;
            idx_r    <= idx_r + 1'b1;
          end
        end
        S_RDPOS: begin
          dvalid_r <= 1'b1;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          case (op_r)
            OP_PUSH:   occ_r <= occ_r + 1'b1;
            OP_POP, OP_REMOVE: occ_r <= occ_r - 1'b1;
            OP_READ: begin
              oprio_r <= rd_prio_r;
              okey_r  <= rd_key_r;
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {6'd0, CNT_W'(occ_r), okey_r, oprio_r, found_r, status_r};

  assert property (@(posedge clk) disable iff (!rst_n) occ_r <= OW'(DEPTH))
    else $error("occupancy above depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_tready) |=> state_r == S_OUT && $stable(out_tdata))
    else $error("result lost while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == OP_PUSH) |=> occ_r == $past(occ_r) + 1'b1)
    else $error("push did not grow queue");

endmodule

@@ sim/sorted_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// A directed table is followed by random traffic. The traffic fills the queue
// past full and drains it past empty, and runs mixed operations over a small
// pool of keys. Every result is compared field by field with a local
// sorted-list predictor, or with the expectation a directed row gives. Both
// stream sides idle and stall at random.
module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned N_RANDOM = 850;
  localparam logic [2:0] KIND_UNDEF_LO = 3'd5;
  localparam logic [2:0] KIND_UNDEF_MID = 3'd6;
  localparam logic [2:0] KIND_UNDEF_HI = 3'd7;
  localparam int PHASE_MIXED = 0;
  localparam int PHASE_FILL = 1;
  localparam int PHASE_DRAIN = 2;

  typedef struct packed {
    logic [5:0]  pad;
    logic [6:0]  count;
    logic [7:0]  speed;
    logic [7:0]  symbol;
    logic [7:0]  y;
    logic [7:0]  x;
    logic [31:0] prio;
    logic        found;
    status_t     status;
  } qresult_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] prio;
    logic [31:0] key;   // x in the low byte, then y, symbol, speed
    logic [5:0]  position;
  } qop_t;

  // Directed row: operation plus an optional typed expectation.
  typedef struct {
    int kind;
    int prio;
    int key;
    int position;
    bit typed;
    int status;
    int found;
    int count;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  always #2 clk = ~clk;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Predictor state: the sorted list as it should be.
  logic [31:0] list_prio [DEPTH];
  logic [31:0] list_key [DEPTH];
  int unsigned list_len = 0;

  qresult_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  bit idle_enable = 1'b1;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  function automatic int find_key(logic [31:0] key);
    for (int i = 0; i < int'(list_len); i++)
      if (list_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void drop_at(int at);
    for (int i = at; i + 1 < int'(list_len); i++) begin
      list_prio[i] = list_prio[i + 1];
      list_key[i] = list_key[i + 1];
    end
    list_len--;
  endfunction

  function automatic qresult_t apply_op(qop_t op);
    qresult_t r;
    int at;
    r = '0;
    r.status = ST_OK;
    case (op.kind)
      OP_PUSH: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // An equal-priority head keeps its place at the front.
          if (list_len == 0 || $signed(op.prio) < $signed(list_prio[0])) at = 0;
          else begin
            at = 1;
            while (at < int'(list_len) && $signed(list_prio[at]) < $signed(op.prio))
              at++;
          end
          for (int i = int'(list_len); i > at; i--) begin
            list_prio[i] = list_prio[i - 1];
            list_key[i] = list_key[i - 1];
          end
          list_prio[at] = op.prio;
          list_key[at] = op.key;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          r.prio = list_prio[0];
          {r.speed, r.symbol, r.y, r.x} = list_key[0];
          drop_at(0);
        end
      end
      OP_REMOVE: begin
        at = find_key(op.key);
        if (at < 0) r.status = ST_NOTFOUND;
        else drop_at(at);
      end
      OP_CONTAINS: r.found = (find_key(op.key) >= 0);
      OP_READ: begin
        if (op.position >= list_len) r.status = ST_EMPTY;
        else begin
          r.prio = list_prio[op.position];
          {r.speed, r.symbol, r.y, r.x} = list_key[op.position];
        end
      end
      default: ;
    endcase
    r.count = list_len[6:0];
    return r;
  endfunction

  // Offer one operation and hold it until the transfer; returns at that edge.
  task automatic send_op(qop_t op, bit typed, qresult_t typed_exp);
    qresult_t predicted;
    in_tvalid <= 1'b1;
    in_tuser <= op.kind;
    in_tdata <= {2'b00, op.position, op.key, op.prio};
    do @(posedge clk); while (!in_tready);
    predicted = apply_op(op);
    if (predicted.status == ST_FULL) full_hits++;
    if (predicted.status == ST_EMPTY && op.kind == OP_POP) empty_hits++;
    pending_results.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic idle_gap();
    if (idle_enable && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 60);
    end
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(3) != 0)
      return {7'd0, 1'($urandom_range(1)), 7'd0, 1'($urandom_range(1)),
              7'd0, 1'($urandom_range(1)), 7'd0, 1'($urandom_range(1))};
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_prio();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return 32'($signed($urandom_range(6)) - 3);
    if (sel < 45) return 32'h8000_0000;
    if (sel < 50) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  function automatic qop_t pick_op(int phase);
    qop_t op;
    int unsigned sel;
    sel = $urandom_range(99);
    op.prio = pick_prio();
    op.key = pick_key();
    op.position = ($urandom_range(3) != 0 && list_len > 0) ?
                  6'($urandom_range(list_len)) : 6'($urandom);
    if (sel < 3) begin
      op.kind = 3'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO));
      return op;
    end
    case (phase)
      PHASE_FILL: op.kind = (sel < 80) ? OP_PUSH : 3'($urandom_range(OP_READ, OP_POP));
      PHASE_DRAIN: op.kind = (sel < 60) ? OP_POP : 3'($urandom_range(OP_READ, OP_PUSH));
      default: op.kind = 3'($urandom_range(OP_READ, OP_PUSH));
    endcase
    return op;
  endfunction

  dir_row_t dir_tab [] = '{
    '{OP_POP,      0,           32'h01020304, 0,  1, ST_EMPTY,    0, 0},
    '{OP_REMOVE,   0,           32'h01020304, 0,  1, ST_NOTFOUND, 0, 0},
    '{OP_READ,     0,           0,            0,  1, ST_EMPTY,    0, 0},
    '{OP_CONTAINS, 0,           32'h01020304, 0,  1, ST_OK,       0, 0},
    '{KIND_UNDEF_LO, 0,         32'hffffffff, 63, 1, ST_OK,       0, 0},
    '{OP_PUSH,     0,           32'h01020304, 0,  1, ST_OK,       0, 1},
    '{OP_PUSH,     32'h80000000, 32'hffffffff, 0, 1, ST_OK,       0, 2},
    '{OP_PUSH,     32'h7fffffff, 32'h00000000, 0, 1, ST_OK,       0, 3},
    '{OP_PUSH,     0,           32'haa55aa55, 0,  0, 0, 0, 0},
    '{OP_PUSH,     32'h80000000, 32'h55aa55aa, 0, 0, 0, 0, 0},
    '{OP_READ,     0,           0,            0,  0, 0, 0, 0},
    '{OP_READ,     0,           0,            1,  0, 0, 0, 0},
    '{OP_READ,     0,           0,            2,  0, 0, 0, 0},
    '{OP_READ,     0,           0,            3,  0, 0, 0, 0},
    '{OP_READ,     0,           0,            4,  0, 0, 0, 0},
    '{OP_CONTAINS, 0,           32'haa55aa55, 0,  0, 0, 0, 0},
    '{OP_CONTAINS, 0,           32'h12345678, 0,  0, 0, 0, 0},
    '{OP_REMOVE,   0,           32'haa55aa55, 0,  0, 0, 0, 0},
    '{OP_REMOVE,   0,           32'h12345678, 0,  0, 0, 0, 0},
    '{OP_READ,     0,           0,            63, 0, 0, 0, 0},
    '{KIND_UNDEF_HI, -1,        32'hffffffff, 0,  0, 0, 0, 0},
    '{KIND_UNDEF_MID, 0,        0,            0,  0, 0, 0, 0},
    '{OP_POP,      0,           0,            0,  0, 0, 0, 0},
    '{OP_POP,      0,           0,            0,  0, 0, 0, 0},
    '{OP_READ,     0,           0,            0,  0, 0, 0, 0}
  };

  // Result side: check each transfer, then choose the next tready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      qresult_t got;
      qresult_t want;
      got = qresult_t'(out_tdata);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected: %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.prio !== want.prio || got.x !== want.x || got.y !== want.y ||
            got.symbol !== want.symbol || got.speed !== want.speed ||
            got.count !== want.count || got.pad !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected st=%0d f=%0d p=%h k=%h%h%h%h n=%0d, got st=%0d f=%0d p=%h k=%h%h%h%h n=%0d pad=%h",
                     results_seen, want.status, want.found, want.prio, want.speed,
                     want.symbol, want.y, want.x, want.count, got.status, got.found,
                     got.prio, got.speed, got.symbol, got.y, got.x, got.count, got.pad);
        end
      end
    end
    // The long hold-off runs once; the sender may still be waiting when it ends.
    if (hold_request && !hold_done && hold_left == 0) begin
      hold_left = 600;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_enable && $urandom_range(99) < 20);
    end
  end

  initial begin
    qop_t op;
    qresult_t typed_exp;
    int phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      op.kind = 3'(dir_tab[i].kind);
      op.prio = dir_tab[i].prio;
      op.key = dir_tab[i].key;
      op.position = 6'(dir_tab[i].position);
      typed_exp = '0;
      typed_exp.status = status_t'(dir_tab[i].status);
      typed_exp.found = dir_tab[i].found[0];
      typed_exp.count = 7'(dir_tab[i].count);
      send_op(op, dir_tab[i].typed, typed_exp);
      idle_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // Blocks of fill and drain drive the list to full and empty in turn.
      case ((n / 100) % 4)
        0: phase = PHASE_FILL;
        1: phase = PHASE_MIXED;
        2: phase = PHASE_DRAIN;
        default: phase = PHASE_MIXED;
      endcase
      idle_enable = !(n >= 300 && n < 450);
      hold_request = (n == 120);
      if (n == 520) begin
        in_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      send_op(pick_op(phase), 1'b0, '0);
      idle_gap();
    end
    in_tvalid <= 1'b0;
    hold_request = 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d directed and %0d random operations, %0d results checked.",
             dir_tab.size(), N_RANDOM, results_seen);
    $display("Push into a full list seen %0d times, pop of an empty list %0d times.",
             full_hits, empty_hits);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
